// ===== rtl/chm_pkg.sv =====
// Shared types and constants for the chained hash multimap.
// No dependencies; imported by chm_front, chm_back and the top level.
package chm_pkg;

    localparam int HASH_W   = 64;
    localparam int ID_W     = 32;
    localparam int CNT_W    = 7;
    localparam int BBITS_W  = 3;
    localparam int MAX_BB   = 6;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [HASH_W-1:0] hash;
        logic [ID_W-1:0]   item_id;
    } cmd_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [ID_W-1:0]  out_id;
        logic             last;
        logic [CNT_W-1:0] occupied_buckets;
        logic [CNT_W-1:0] entry_count;
    } result_t;

    // Classified operation handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]      cmd;
        logic [MAX_BB-1:0] bucket;
        logic [ID_W-1:0] item_id;
    } op_t;

endpackage

// ===== rtl/chm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/chm_front.sv =====
// Front end: accepts commands, masks the hash to a bucket, and queues the op.
// Depends on chm_pkg.
module chm_front
    import chm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cmd_in_t            cmd_in,
    input  logic [BBITS_W-1:0] bucket_bits,
    output logic               busy,
    output logic               q_valid,
    output op_t                q_op,
    input  logic               q_pop
);

    // Two-entry queue between the front and back ends.
    op_t        q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic [2:0] bits_eff;
    logic [MAX_BB-1:0] mask;
    logic       push;
    op_t        op;

    always_comb
    begin
        if (bucket_bits == 3'd0)
            bits_eff = 3'd1;
        else if (bucket_bits > 3'(MAX_BB))
            bits_eff = 3'(MAX_BB);
        else
            bits_eff = bucket_bits;
        mask = MAX_BB'((7'd1 << bits_eff) - 7'd1);
        op.cmd     = cmd_in.cmd;
        op.bucket  = cmd_in.hash[MAX_BB-1:0] & mask;
        op.item_id = cmd_in.item_id;
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_op    = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) !(push && count_reg == 2'd2);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_pop_valid;
        @(posedge clk) disable iff (!rst_n) q_pop |-> q_valid;
    endproperty
    a_pop_valid: assert property (p_pop_valid) else $error("pop from empty queue");

    property p_count_range;
        @(posedge clk) disable iff (!rst_n) count_reg != 2'd3;
    endproperty
    a_count_range: assert property (p_count_range) else $error("bad queue count");

endmodule

// ===== rtl/chm_back.sv =====
// Back end: executes add, lookup and clear by walking bucket chains.
// Depends on chm_pkg and chm_ram.
module chm_back
    import chm_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  op_t     q_op,
    output logic    q_pop,
    output logic    res_valid,
    output result_t res
);

    localparam int NB    = 1 << MAX_BB;
    localparam int EA_W  = $clog2(MAX_ENTRIES);
    localparam int LEN_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WAIT, S_WALK, S_DONE
    } state_t;

    state_t           state_reg;
    op_t              op_reg;
    logic [EA_W-1:0]  cur_reg;
    logic [LEN_W-1:0] steps_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] nonempty_reg;
    logic [NB-1:0]    head_valid_reg;
    logic [MAX_ENTRIES-1:0] next_valid_reg;
    logic             res_valid_reg;
    result_t          res_reg;

    // Entry store: id and next pointer, one RAM each.
    logic             id_we, nx_we;
    logic [EA_W-1:0]  id_waddr, nx_waddr, raddr;
    logic [ID_W-1:0]  id_wdata, id_rdata;
    logic [EA_W-1:0]  nx_wdata, nx_rdata;

    // Bucket heads. The read is issued at the pop, so the head of the
    // popped op's bucket is on head_rdata during S_READ.
    logic             head_we;
    logic [EA_W-1:0]  head_rdata;

    chm_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_id_ram (
        .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
        .raddr(raddr), .rdata(id_rdata)
    );

    chm_ram #(.WIDTH(EA_W), .DEPTH(MAX_ENTRIES)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(raddr), .rdata(nx_rdata)
    );

    logic full;
    logic [EA_W-1:0] slot;
    logic cur_has_next;

    chm_ram #(.WIDTH(EA_W), .DEPTH(NB)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(op_reg.bucket), .wdata(slot),
        .raddr(q_op.bucket), .rdata(head_rdata)
    );

    assign full         = (used_reg >= CNT_W'(MAX_ENTRIES));
    assign slot         = used_reg[EA_W-1:0];
    assign cur_has_next = next_valid_reg[cur_reg];
    assign raddr        = cur_reg;
    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign res_valid    = res_valid_reg;
    assign res          = res_reg;

    // RAM writes happen in S_WALK for an add that reaches the chain tail
    // and in S_READ for an add into an empty bucket.
    always_comb
    begin
        id_we    = 1'b0;
        nx_we    = 1'b0;
        head_we  = 1'b0;
        id_waddr = slot;
        id_wdata = op_reg.item_id;
        nx_waddr = cur_reg;
        nx_wdata = slot;
        if (state_reg == S_READ && op_reg.cmd == CMD_ADD && !full
            && !head_valid_reg[op_reg.bucket])
        begin
            id_we   = 1'b1;
            head_we = 1'b1;
        end
        if (state_reg == S_WALK && op_reg.cmd == CMD_ADD
            && id_rdata != op_reg.item_id
            && !(cur_has_next && steps_reg + LEN_W'(1) < LEN_W'(MAX_ENTRIES)))
        begin
            id_we = 1'b1;
            nx_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            op_reg <= q_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            nonempty_reg   <= '0;
            head_valid_reg <= '0;
            next_valid_reg <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
            cur_reg        <= '0;
            steps_reg      <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    res_reg.status           <= ST_OK;
                    res_reg.found            <= 1'b0;
                    res_reg.out_id           <= '0;
                    res_reg.last             <= 1'b1;
                    res_reg.occupied_buckets <= nonempty_reg;
                    res_reg.entry_count      <= used_reg;
                    cur_reg   <= head_rdata;
                    steps_reg <= '0;
                    state_reg <= S_DONE;
                    case (op_reg.cmd)
                        CMD_ADD:
                        begin
                            if (full)
                            begin
                                res_reg.status <= ST_FULL;
                                res_valid_reg  <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else if (!head_valid_reg[op_reg.bucket])
                            begin
                                head_valid_reg[op_reg.bucket] <= 1'b1;
                                next_valid_reg[slot]          <= 1'b0;
                                nonempty_reg                  <= nonempty_reg + 1'b1;
                                used_reg                      <= used_reg + 1'b1;
                                res_reg.occupied_buckets      <= nonempty_reg + 1'b1;
                                res_reg.entry_count           <= used_reg + 1'b1;
                                res_valid_reg                 <= 1'b1;
                                state_reg                     <= S_IDLE;
                            end
                            else
                                state_reg <= S_WAIT;
                        end
                        CMD_LOOKUP:
                        begin
                            if (head_valid_reg[op_reg.bucket])
                                state_reg <= S_WAIT;
                            else
                            begin
                                res_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            head_valid_reg           <= '0;
                            next_valid_reg           <= '0;
                            used_reg                 <= '0;
                            nonempty_reg             <= '0;
                            res_reg.occupied_buckets <= '0;
                            res_reg.entry_count      <= '0;
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        default:
                        begin
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    endcase
                end
                S_WAIT:
                begin
                    // RAM read of cur_reg lands at the next edge.
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (op_reg.cmd == CMD_LOOKUP)
                    begin
                        res_reg.status <= ST_OK;
                        res_reg.found  <= 1'b1;
                        res_reg.out_id <= id_rdata;
                        res_valid_reg  <= 1'b1;
                        if (cur_has_next && steps_reg + LEN_W'(1) < LEN_W'(MAX_ENTRIES))
                        begin
                            res_reg.last <= 1'b0;
                            cur_reg      <= nx_rdata;
                            steps_reg    <= steps_reg + 1'b1;
                            state_reg    <= S_WAIT;
                        end
                        else
                        begin
                            res_reg.last <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end
                    else if (id_rdata == op_reg.item_id)
                    begin
                        res_reg.status <= ST_DUP;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else if (cur_has_next && steps_reg + LEN_W'(1) < LEN_W'(MAX_ENTRIES))
                    begin
                        cur_reg   <= nx_rdata;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        next_valid_reg[cur_reg] <= 1'b1;
                        next_valid_reg[slot]    <= 1'b0;
                        used_reg                <= used_reg + 1'b1;
                        res_reg.entry_count     <= used_reg + 1'b1;
                        res_valid_reg           <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) used_reg <= CNT_W'(MAX_ENTRIES);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("entry count overflow");

    property p_buckets_le_entries;
        @(posedge clk) disable iff (!rst_n) nonempty_reg <= used_reg;
    endproperty
    a_buckets_le_entries: assert property (p_buckets_le_entries)
        else $error("more buckets than entries");

    property p_result_idle;
        @(posedge clk) disable iff (!rst_n)
            (res_valid && res.last) |-> (state_reg == S_IDLE);
    endproperty
    a_result_idle: assert property (p_result_idle) else $error("last result while busy");

endmodule

// ===== rtl/chained_hash_multimap.sv =====
// Top level of the chained hash multimap: front end, queue and back end.
// Depends on chm_pkg, chm_front, chm_back and chm_ram.
//
// Usage: raise start with cmd_in for one cycle; the command transfers when
// busy is low. Commands queue in a two-entry buffer, so start may be given
// while earlier work is in progress. Each result appears on res for one
// cycle with res_valid high; the receiver cannot stall. A lookup gives one
// result per id in its bucket chain, the final one with last set; a lookup
// of an empty bucket gives a single result with found low and last set.
// Clear, full adds, adds to an empty bucket and empty lookups are answered
// from S_READ. Adds and lookups on a chain walk it one entry at a time via
// S_WAIT and S_WALK, limited by the registered read of the entry RAMs; the
// back end takes the next queued command only once back in S_IDLE.
// bucket_bits is written with cfg_we/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Reset empties all buckets and zeroes the counts; no clearing pass runs.
module chained_hash_multimap
    import chm_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cmd_in_t            cmd_in,
    output logic               busy,
    output logic               res_valid,
    output result_t            res,
    input  logic               cfg_we,
    input  logic [BBITS_W-1:0] cfg_data
);

    logic [BBITS_W-1:0] bucket_bits_reg;
    logic q_valid, q_pop;
    op_t  q_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_bits_reg <= 3'(MAX_BB);
        else if (cfg_we)
            bucket_bits_reg <= cfg_data;
    end

    chm_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd_in(cmd_in),
        .bucket_bits(bucket_bits_reg), .busy(busy),
        .q_valid(q_valid), .q_op(q_op), .q_pop(q_pop)
    );

    chm_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_op(q_op),
        .q_pop(q_pop), .res_valid(res_valid), .res(res)
    );

endmodule
